[rtl/rfc_pkg.sv]
// Shared constants and helpers for the three-rail fence cipher.
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'h7A;

  // ASCII letter test; high bytes never match.
  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= UPPER_FIRST) && (c <= UPPER_LAST)) ||
           ((c >= LOWER_FIRST) && (c <= LOWER_LAST));
  endfunction

endpackage

`default_nettype wire

[rtl/rfc_in_if.sv]
// Input request channel: one message byte and its end-of-message mark.
`timescale 1ns / 1ps
`default_nettype none

interface rfc_in_if;
  logic                       valid;
  logic                       ready;
  logic [rfc_pkg::CHAR_W-1:0] in_char;
  logic                       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

[rtl/rfc_out_if.sv]
// Result request channel: one permuted letter with its flags.
`timescale 1ns / 1ps
`default_nettype none

interface rfc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rfc_pkg::CHAR_W-1:0] out_char;
  logic                       out_last;
  logic                       out_truncated;

  modport source (output valid, output out_char, output out_last, output out_truncated,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input out_truncated,
                  output ready);
endinterface

`default_nettype wire

[rtl/rfc_addr_unit.sv]
// Rail address unit: maps an output index to a letter store address.
`timescale 1ns / 1ps
`default_nettype none

module rfc_addr_unit #(
  parameter int unsigned MAX_LETTERS = 64
) (
  input  wire logic [$clog2(MAX_LETTERS+1)-1:0] idx,
  input  wire logic [$clog2(MAX_LETTERS+1)-1:0] rail0_cnt,  // letters on top rail
  input  wire logic [$clog2(MAX_LETTERS+1)-1:0] rail01_cnt, // top plus middle rail
  input  wire logic                             decipher,
  output logic      [$clog2(MAX_LETTERS)-1:0]   addr
);

  localparam int unsigned CW = $clog2(MAX_LETTERS + 1);
  localparam int unsigned AW = $clog2(MAX_LETTERS);

  logic [CW-1:0] diff;
  logic [CW-1:0] half_sum;

  always_comb begin
    diff     = '0;
    half_sum = '0;
    addr     = '0;
    if (!decipher) begin
      // Encipher: idx walks the rails, addr is the source position.
      if (idx < rail0_cnt) begin
        addr = AW'({idx, 2'b00});
      end else if (idx < rail01_cnt) begin
        diff = idx - rail0_cnt;
        addr = AW'({diff, 1'b1});
      end else begin
        diff = idx - rail01_cnt;
        addr = AW'({diff, 2'b10});
      end
    end else begin
      // Decipher: idx is the original position, addr its rank in rail order.
      if (idx[0]) begin
        half_sum = rail0_cnt + (idx >> 1);
        addr     = AW'(half_sum);
      end else if (!idx[1]) begin
        addr = AW'(idx >> 2);
      end else begin
        half_sum = rail01_cnt + (idx >> 2);
        addr     = AW'(half_sum);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/three_rail_fence_cipher_core.sv]
// Three-rail fence cipher core: letter store, output sequencer and rail addressing.
`timescale 1ns / 1ps
`default_nettype none
// Load: one byte per cycle, ready high whenever no message is being emitted.
// Emit: after the edge that takes the last byte, the sequencer issues a store read
//   (S_READ) and then presents the result (S_EMIT) for each letter; the next read
//   starts only once the sink takes the current result, over the single store read port.
// Reset (rst_n, sync, active low) clears count, overflow, mode and sequencer;
//   the letter store holds no reset and needs no clearing pass.

module three_rail_fence_cipher_core #(
  parameter int unsigned MAX_LETTERS = 64   // store capacity, 4..64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  rfc_in_if.sink     in_if,
  rfc_out_if.source  out_if
);

  localparam int unsigned CW = $clog2(MAX_LETTERS + 1);
  localparam int unsigned AW = $clog2(MAX_LETTERS);
  localparam logic [CW-1:0] CAP = CW'(MAX_LETTERS);

  typedef enum logic [1:0] {
    S_LOAD,   // taking message bytes
    S_READ,   // store read issued for result k
    S_EMIT    // result k held on the output
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;     // letters stored
  logic          ovf_r, ovf_nxt;         // a letter was dropped
  logic [CW-1:0] n_r, n_nxt;             // letters in the message being emitted
  logic [CW-1:0] rail0_r, rail0_nxt;     // ceil(n/4)
  logic [CW-1:0] rail01_r, rail01_nxt;   // ceil(n/4) + floor(n/2)
  logic [CW-1:0] k_r, k_nxt;             // result index
  logic          last_r, last_nxt;
  logic          mode_r;

  logic [rfc_pkg::CHAR_W-1:0] store_r [MAX_LETTERS];
  logic [rfc_pkg::CHAR_W-1:0] rdata_r;

  logic          in_take;
  logic          letter;
  logic          store_we;
  logic [CW-1:0] count_inc;
  logic [CW:0]   rail0_wide;
  logic [AW-1:0] rd_addr;

  assign in_if.ready = (state_r == S_LOAD);
  assign in_take     = in_if.valid && in_if.ready;
  assign letter      = rfc_pkg::is_letter(in_if.in_char);
  assign store_we    = in_take && letter && (count_r < CAP);
  assign count_inc   = store_we ? (count_r + CW'(1)) : count_r;
  assign rail0_wide  = ({1'b0, count_inc} + (CW + 1)'(3)) >> 2;

  assign out_if.valid         = (state_r == S_EMIT);
  assign out_if.out_char      = rdata_r;
  assign out_if.out_last      = last_r;
  assign out_if.out_truncated = ovf_r;

  // Mode register; the user must write it only while idle, the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  rfc_addr_unit #(
    .MAX_LETTERS (MAX_LETTERS)
  ) u_addr (
    .idx        (k_r),
    .rail0_cnt  (rail0_r),
    .rail01_cnt (rail01_r),
    .decipher   (mode_r),
    .addr       (rd_addr)
  );

  // Letter store: one write port in load, one registered read port in emit.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[count_r[AW-1:0]] <= in_if.in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rdata_r <= store_r[rd_addr];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    n_nxt      = n_r;
    rail0_nxt  = rail0_r;
    rail01_nxt = rail01_r;
    k_nxt      = k_r;
    last_nxt   = last_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_take) begin
          count_nxt = count_inc;
          if (letter && !store_we) begin
            ovf_nxt = 1'b1;
          end
          if (in_if.in_last) begin
            if (count_inc == '0) begin
              // empty message: nothing to emit, just start over
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end else begin
              n_nxt      = count_inc;
              rail0_nxt  = rail0_wide[CW-1:0];
              rail01_nxt = rail0_wide[CW-1:0] + (count_inc >> 1);
              k_nxt      = '0;
              state_nxt  = S_READ;
            end
          end
        end
      end
      S_READ: begin
        last_nxt  = (k_r + CW'(1) == n_r);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_if.ready) begin
          if (last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      n_r      <= '0;
      rail0_r  <= '0;
      rail01_r <= '0;
      k_r      <= '0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      n_r      <= n_nxt;
      rail0_r  <= rail0_nxt;
      rail01_r <= rail01_nxt;
      k_r      <= k_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench for the three-rail fence cipher core: directed and random messages against a rail-order predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned STORE_SLOTS = 64;      // matches the core's default capacity
  localparam int unsigned RUN_LIMIT   = 400000;  // cycles before the run is declared hung
  localparam int unsigned MAX_PRINTED = 40;
  localparam int unsigned BYTE_TARGET = 370;
  localparam int unsigned DRAIN_WAIT  = 8;       // settling wait after the last pending letter is checked

  typedef logic [rfc_pkg::CHAR_W-1:0] char_t;
  typedef char_t text_t[$];

  typedef struct packed {
    char_t ch;
    logic  last;
    logic  truncated;
  } cipher_letter_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  rfc_in_if  in_ch ();
  rfc_out_if out_ch ();

  three_rail_fence_cipher_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Predictor copy of the core state.
  char_t          plain_store [STORE_SLOTS];
  int unsigned    stored_letters;
  logic           dropped_letters;
  logic           decipher_on;
  cipher_letter_t expected_letters [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  logic        steady      = 1'b0;  // when set, neither side idles
  logic        in_held     = 1'b0;  // source valid currently driven high
  logic        out_open    = 1'b0;  // sink ready currently driven high

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Letter test by case folding: clearing bit 5 maps lower case onto upper case.
  function automatic logic is_alpha(input char_t c);
    char_t folded;
    folded = c & 8'hDF;
    return (c[7] == 1'b0) && (folded >= 8'h41) && (folded <= 8'h5A);
  endfunction

  function automatic int draw_gap();
    if (steady) return 0;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // Stores a letter; on the last byte, queues the whole permuted message.
  function automatic void absorb_byte(input char_t c, input logic last);
    int unsigned    order [STORE_SLOTS];
    char_t          permuted [STORE_SLOTS];
    int unsigned    n;
    int unsigned    k;
    int unsigned    pos;
    cipher_letter_t item;
    if (is_alpha(c)) begin
      if (stored_letters < STORE_SLOTS) begin
        plain_store[stored_letters] = c;
        stored_letters++;
      end else begin
        dropped_letters = 1'b1;
      end
    end
    if (!last) return;
    n = stored_letters;
    k = 0;
    // Rail read order: top rail, middle rail, bottom rail.
    for (pos = 0; pos < n; pos += 4) begin order[k] = pos; k++; end
    for (pos = 1; pos < n; pos += 2) begin order[k] = pos; k++; end
    for (pos = 2; pos < n; pos += 4) begin order[k] = pos; k++; end
    for (k = 0; k < n; k++) begin
      if (decipher_on) permuted[order[k]] = plain_store[k];
      else permuted[k] = plain_store[order[k]];
    end
    for (k = 0; k < n; k++) begin
      item.ch        = permuted[k];
      item.last      = (k + 1 == n);
      item.truncated = dropped_letters;
      expected_letters.push_back(item);
    end
    stored_letters  = 0;
    dropped_letters = 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_letter();
    cipher_letter_t want;
    if (expected_letters.size() == 0) begin
      report_mismatch($sformatf("letter %02h arrived with nothing pending", out_ch.out_char));
      return;
    end
    want = expected_letters.pop_front();
    if (out_ch.out_char !== want.ch)
      report_mismatch($sformatf("out_char %02h, expected %02h", out_ch.out_char, want.ch));
    if (out_ch.out_last !== want.last)
      report_mismatch($sformatf("out_last %b, expected %b", out_ch.out_last, want.last));
    if (out_ch.out_truncated !== want.truncated)
      report_mismatch($sformatf("out_truncated %b, expected %b",
                                out_ch.out_truncated, want.truncated));
  endtask

  // Observes config writes and both handshakes at the edge that accepts them.
  always @(posedge clk) begin
    if (!rst_n) begin
      stored_letters  = 0;
      dropped_letters = 1'b0;
      decipher_on     = 1'b0;
      expected_letters.delete();
    end else begin
      if (cfg_we === 1'b1) decipher_on = cfg_wdata;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        absorb_byte(in_ch.in_char, in_ch.in_last);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        check_letter();
    end
  end

  // Result side: random stall before each request is taken.
  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        if (out_open) begin
          out_ch.ready <= 1'b0;
          out_open = 1'b0;
        end
        repeat (gap) @(posedge clk);
      end
      if (!out_open) begin
        out_ch.ready <= 1'b1;
        out_open = 1'b1;
      end
      @(posedge clk);
      while (!(rst_n === 1'b1 && out_ch.valid === 1'b1)) @(posedge clk);
    end
  end

  // Sends one byte and returns at the edge that took it, plus a random gap.
  // Valid stays high when the gap is zero, so back-to-back requests never toggle it.
  task automatic send_byte(input char_t c, input logic last);
    int gap;
    in_ch.in_char <= c;
    in_ch.in_last <= last;
    if (!in_held) begin
      in_ch.valid <= 1'b1;
      in_held = 1'b1;
    end
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input text_t msg);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Drops valid, waits out every pending letter, then lets an empty message finish.
  task automatic wait_quiet();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    @(posedge clk);
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_mode(input logic decipher);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= decipher;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic text_t make_text(input int unsigned len, input int unsigned letter_pct);
    text_t msg;
    char_t base;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < letter_pct) begin
        base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
        msg.push_back(base + char_t'($urandom_range(0, 25)));
      end else begin
        msg.push_back(char_t'($urandom_range(0, 255)));
      end
    end
    return msg;
  endfunction

  // Empty message, a lone letter, and the bytes on each side of both letter ranges.
  task automatic test_letter_edges();
    set_mode(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h41, 1'b1);
    send_message('{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'h80, 8'hFF});
  endtask

  // Short messages in decipher mode, down to two and three letters.
  task automatic test_short_decipher();
    set_mode(1'b1);
    send_message('{8'h48, 8'h4F, 8'h4C, 8'h45, 8'h4C});
    send_message('{8'h71, 8'h51});
    send_message('{8'h78, 8'h7A, 8'h79});
  endtask

  // Exactly full store, then overflow with the last byte itself dropped.
  task automatic test_full_store();
    text_t msg;
    set_mode(1'b0);
    msg = make_text(STORE_SLOTS, 100);
    msg.push_back(8'h20);
    send_message(msg);
    set_mode(1'b1);
    send_message(make_text(STORE_SLOTS + 3, 100));
  endtask

  // Mostly short well-formed messages; a few long, overflowing or letter-free ones.
  task automatic test_random_messages();
    int unsigned len;
    int unsigned pct;
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 4) == 0) steady = ~steady;
      if ($urandom_range(0, 3) == 0) set_mode(1'($urandom_range(0, 1)));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 72) : $urandom_range(1, 16);
      pct = ($urandom_range(0, 7) == 0) ? 0 : 85;
      send_message(make_text(len, pct));
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = '0;
    in_ch.in_last = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_letter_edges();
    test_short_decipher();
    test_full_store();
    test_random_messages();

    wait_quiet();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
